// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked during reset.
`define ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication across reset");

`endif

// ===== hdl/gfl_pkg.sv =====
package gfl_pkg;

    localparam int unsigned IDX_W          = 10;
    localparam int unsigned CNT_W          = 11;
    localparam int unsigned CFG_W          = 11;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam int unsigned S_TDATA_W      = 16;
    localparam int unsigned M_TDATA_W      = 16;
    localparam int unsigned DEF_MAX_BLOCKS = 1024;
    // Block counts and indexes never reach past what the count width holds.
    localparam int unsigned MEM_DEPTH_CAP  = 2 ** CNT_W;

    localparam logic [CFG_W-1:0] RST_GROW_N = 11'd16;
    localparam logic [CFG_W-1:0] RST_MAX_N  = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_GROW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 1'b1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EXHAUSTED = 2'd1;
    localparam t_status ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] grow_n;
        logic [CFG_W-1:0] max_n;
    } t_cfg;

    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] waddr;
        logic [CNT_W-1:0] wlink;
        logic             wlast;
        logic             re;
        logic [CNT_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [CNT_W-1:0] link;
        logic             last;
    } t_mem_rsp;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        t_status          status;
    } t_result;

endpackage

// ===== hdl/gfl_link_mem.sv =====
module gfl_link_mem #(
    parameter int unsigned MAX_BLOCKS = gfl_pkg::DEF_MAX_BLOCKS
) (
    input  logic              i_clk,
    input  gfl_pkg::t_mem_req i_req,
    output gfl_pkg::t_mem_rsp o_rsp
);
    import gfl_pkg::*;

    localparam int unsigned DEPTH = (MAX_BLOCKS < MEM_DEPTH_CAP) ? MAX_BLOCKS : MEM_DEPTH_CAP;
    localparam int unsigned AW    = $clog2(DEPTH);

    // Each entry holds the successor link and the end-of-list flag.
    logic [AW:0] r_mem [DEPTH];
    logic [AW:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= {i_req.wlink[AW-1:0], i_req.wlast};
        end
        if (i_req.re) begin
            r_rd <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rsp.link = CNT_W'(r_rd[AW:1]);
    assign o_rsp.last = r_rd[0];

endmodule

// ===== hdl/gfl_ctrl.sv =====
module gfl_ctrl #(
    parameter int unsigned MAX_BLOCKS = gfl_pkg::DEF_MAX_BLOCKS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic [gfl_pkg::IDX_W-1:0]   i_free_index,
    input  gfl_pkg::t_cfg               i_cfg,
    input  logic                        i_slot_free,
    output logic                        o_res_valid,
    output gfl_pkg::t_result            o_res,
    output gfl_pkg::t_mem_req           o_mem_req,
    input  gfl_pkg::t_mem_rsp           i_mem_rsp
);
    import gfl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_GROW = 2'd2;

    localparam int unsigned LIMIT_CAP_I =
        (MAX_BLOCKS < MEM_DEPTH_CAP - 1) ? MAX_BLOCKS : MEM_DEPTH_CAP - 1;
    localparam logic [CNT_W-1:0] LIMIT_CAP = CNT_W'(LIMIT_CAP_I);

    logic [1:0]       r_state, n_state;
    logic             r_kind, n_kind;
    logic [IDX_W-1:0] r_fidx, n_fidx;
    logic [CNT_W-1:0] r_head, n_head;
    logic             r_empty, n_empty;
    logic [CNT_W-1:0] r_committed, n_committed;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [CNT_W-1:0] limit;
    logic [CNT_W:0]   grow_end;
    logic             grow_fail;
    logic [CNT_W-1:0] grow_blk;
    logic [CNT_W-1:0] grow_nxt;
    logic [CNT_W-1:0] first_nxt;
    logic             grow_last;

    assign limit     = (i_cfg.max_n < LIMIT_CAP) ? i_cfg.max_n : LIMIT_CAP;
    assign grow_end  = {1'b0, r_committed} + {1'b0, i_cfg.grow_n};
    assign grow_fail = (i_cfg.grow_n == '0) || (grow_end > {1'b0, limit});
    assign grow_blk  = r_committed + r_cnt;
    assign grow_nxt  = grow_blk + CNT_W'(1);
    assign first_nxt = r_committed + CNT_W'(1);
    assign grow_last = (r_cnt == i_cfg.grow_n - CNT_W'(1));

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_fidx      = r_fidx;
        n_head      = r_head;
        n_empty     = r_empty;
        n_committed = r_committed;
        n_cnt       = r_cnt;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_mem_req   = '0;
        // The head link is read while idle, so a pop finds it ready in the
        // execute cycle. Writes happen only outside idle, so they never race it.
        o_mem_req.re    = (r_state == S_IDLE);
        o_mem_req.raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_fidx  = i_free_index;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_kind == KIND_FREE) begin
                    if (i_slot_free) begin
                        o_res_valid = 1'b1;
                        n_state     = S_IDLE;
                        if ({1'b0, r_fidx} >= r_committed) begin
                            o_res.status = ST_BAD_INDEX;
                        end else begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.waddr = {1'b0, r_fidx};
                            o_mem_req.wlink = r_head;
                            o_mem_req.wlast = r_empty;
                            n_head          = {1'b0, r_fidx};
                            n_empty         = 1'b0;
                            o_res.status    = ST_OK;
                        end
                    end
                end else if (!r_empty) begin
                    if (i_slot_free) begin
                        o_res_valid  = 1'b1;
                        o_res.index  = r_head[IDX_W-1:0];
                        o_res.status = ST_OK;
                        n_state      = S_IDLE;
                        if (i_mem_rsp.last) begin
                            n_empty = 1'b1;
                            n_head  = '0;
                        end else begin
                            n_head = i_mem_rsp.link;
                        end
                    end
                end else if (grow_fail) begin
                    if (i_slot_free) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_EXHAUSTED;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_cnt   = '0;
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                // Chain the new blocks in index order, one link write a cycle.
                // The last write repeats harmlessly while the result waits.
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = grow_blk;
                o_mem_req.wlink = {1'b0, grow_nxt[IDX_W-1:0]};
                o_mem_req.wlast = grow_last;
                if (!grow_last) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (i_slot_free) begin
                    // The first new block goes out at once; its link is known.
                    o_res_valid  = 1'b1;
                    o_res.index  = r_committed[IDX_W-1:0];
                    o_res.status = ST_OK;
                    n_committed  = grow_end[CNT_W-1:0];
                    n_state      = S_IDLE;
                    if (i_cfg.grow_n == CNT_W'(1)) begin
                        n_empty = 1'b1;
                        n_head  = '0;
                    end else begin
                        n_empty = 1'b0;
                        n_head  = {1'b0, first_nxt[IDX_W-1:0]};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_empty     <= 1'b1;
            r_committed <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_empty     <= n_empty;
            r_committed <= n_committed;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_fidx <= n_fidx;
    end

endmodule

// ===== hdl/growable_free_list_block_pool.sv =====
// Fixed-size block pool kept as a linked free list in a single-port-write link
// memory. Each item is an allocate or a free, and each gives exactly one result.
// A free, a failed allocate and an allocate from a non-empty list pass through
// the accept cycle, during which the head link is read from the memory, and the
// execute cycle. An allocate on an empty list that grows the pool then chains
// the new blocks one link write a cycle through the memory's write port. Results
// sit in an output register; the next item is accepted while a result waits, and
// its execute cycle holds until that register is free. The link memory needs no
// clearing after reset.
module growable_free_list_block_pool #(
    parameter int unsigned MAX_BLOCKS = gfl_pkg::DEF_MAX_BLOCKS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [gfl_pkg::S_TDATA_W-1:0]     i_s_tdata,   // [9:0] free_index
    input  logic [0:0]                        i_s_tuser,   // [0] kind
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [gfl_pkg::M_TDATA_W-1:0]     o_m_tdata,   // [9:0] block_index
    output logic [1:0]                        o_m_tuser,   // [1:0] status
    input  logic                              i_cfg_we,
    input  logic [gfl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gfl_pkg::CFG_W-1:0]         i_cfg_data
);
    import gfl_pkg::*;

    t_cfg     r_cfg;
    logic     r_out_valid;
    t_result  r_out;

    logic     slot_free;
    logic     res_valid;
    t_result  res;
    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grow_n <= RST_GROW_N;
            r_cfg.max_n  <= RST_MAX_N;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GROW: r_cfg.grow_n <= i_cfg_data;
                CFG_MAX:  r_cfg.max_n  <= i_cfg_data;
                default:  r_cfg        <= r_cfg;
            endcase
        end
    end

    assign slot_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    gfl_ctrl #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_kind       (i_s_tuser[0]),
        .i_free_index (i_s_tdata[IDX_W-1:0]),
        .i_cfg        (r_cfg),
        .i_slot_free  (slot_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_mem_req    (mem_req),
        .i_mem_rsp    (mem_rsp)
    );

    gfl_link_mem #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_link_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out.index);
    assign o_m_tuser  = r_out.status;

endmodule

// ===== hdl/gfl_checker.sv =====
`include "assert_macros.svh"

module gfl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [gfl_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [1:0]                    o_m_tuser
);
    import gfl_pkg::*;

    logic out_stall;

    assign out_stall = o_m_tvalid && !i_m_tready;

    // A stalled result keeps its place and its contents.
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_tvalid && $stable({o_m_tdata, o_m_tuser}))

    // Failed allocates and rejected frees never report a block index.
    `ASSERT_IMP(a_fail_zero_index, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != ST_OK, o_m_tdata == '0)

    // Items are worked one at a time: an accept always closes the input in the next cycle.
    `ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // Reset empties the output and leaves the block ready for an item.
    `ASSERT_NXT_ALWAYS(a_reset_state, i_clk, !i_rst_n, !o_m_tvalid && o_s_tready)

endmodule

bind growable_free_list_block_pool gfl_checker u_gfl_checker (.*);
